FILE: design/nsl_pkg.sv
// shared types and constants for the nearest symbol lookup table
`default_nettype none

package nsl_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int ADDR_W          = 64;
  localparam int TAG_W           = 16;
  localparam int IN_DATA_W       = 80;
  localparam int OUT_DATA_W      = 152;

  // request kind carried on s_tuser
  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_LOOKUP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // one stored symbol entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] start;
  } entry_t;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic take;
  } scan_ctl_t;

  // best candidate so far
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] off;
    logic [TAG_W-1:0]  tag;
  } best_t;

endpackage

`default_nettype wire

FILE: design/nsl_entry_ram.sv
// symbol entry memory, one write port and one registered read port
`default_nettype none

module nsl_entry_ram
  import nsl_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output      entry_t           rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/nsl_scan.sv
// compare unit that keeps the closest entry at or below the query
`default_nettype none

module nsl_scan
  import nsl_pkg::*;
(
  input  wire logic              clk,
  input  wire scan_ctl_t         ctl,
  input  wire logic [ADDR_W-1:0] query_in,
  input  wire entry_t            ent,
  output      best_t             best
);

  logic [ADDR_W-1:0] query;
  logic [ADDR_W-1:0] off;
  logic              below;
  logic              better;

  // candidate offset and ordering; strict less keeps the earliest entry on ties
  always_comb begin
    below  = (ent.start <= query);
    off    = query - ent.start;
    better = below && (!best.found || (off < best.off));
  end

  // query latch and best tracking
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      query      <= query_in;
      best.found <= 1'b0;
      best.addr  <= '0;
      best.off   <= '0;
      best.tag   <= '0;
    end else if (ctl.take && better) begin
      best.found <= 1'b1;
      best.addr  <= ent.start;
      best.off   <= off;
      best.tag   <= ent.tag;
    end
  end

endmodule

`default_nettype wire

FILE: design/nearest_symbol_lookup_table.sv
// Nearest symbol lookup table: one request at a time.
// Register request, or lookup on an empty table: result state, then output register.
// Lookup: scan reads the entry memory one entry per cycle over the N filled entries,
// then drain, result and output register; next request taken as the result appears.
// Reset clears the fill count and control and holds s_tready low; the entry memory
// is not cleared, only filled entries are ever read.
`default_nettype none

module nearest_symbol_lookup_table
  import nsl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // address[63:0], symbol_tag[79:64]
  input  wire logic [0:0]            s_tuser,  // func[0]
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata   // found[0], match_address[64:1],
                                               // match_offset[128:65], match_tag[144:129],
                                               // table_full[145], zero[151:146]
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_pend;
  logic              res_full;

  logic              accept;
  logic              is_lookup;
  logic              has_room;
  logic              last_rd;
  logic              out_free;
  logic              we;
  logic              re;
  scan_ctl_t         scan_ctl;
  entry_t            wr_ent;
  entry_t            rd_ent;
  best_t             best;

  // request decode
  always_comb begin
    accept    = s_tvalid && s_tready;
    is_lookup = (s_tuser[0] == FUNC_LOOKUP);
    has_room  = (count < CNT_W'(TABLE_DEPTH));
    last_rd   = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
    out_free  = !m_tvalid || m_tready;
    wr_ent.start = s_tdata[ADDR_W-1:0];
    wr_ent.tag   = s_tdata[ADDR_W+TAG_W-1:ADDR_W];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_lookup && (count != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_tready       = 1'b0;
    we             = 1'b0;
    re             = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.take  = rd_pend;
    case (state)
      ST_IDLE: begin
        s_tready       = !rst;
        scan_ctl.clear = accept;
        we             = accept && !is_lookup && has_room;
      end
      ST_SCAN: begin
        re = 1'b1;
      end
      ST_DRAIN,
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= re;
      if (we) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // scan index and dropped-register flag
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx   <= '0;
      res_full <= !is_lookup && !has_room;
    end else if (re) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {6'b0, res_full, best.tag, best.off, best.addr, best.found};
    end
  end

  nsl_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_ent),
    .re    (re),
    .raddr (rd_idx),
    .rdata (rd_ent)
  );

  nsl_scan u_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .query_in (s_tdata[ADDR_W-1:0]),
    .ent      (rd_ent),
    .best     (best)
  );

endmodule

`default_nettype wire
